FILE: hdl/hill_cipher_2x2_encrypt_unit_assert.svh
`ifndef HILL_CIPHER_2X2_ENCRYPT_UNIT_ASSERT_SVH
`define HILL_CIPHER_2X2_ENCRYPT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HC2_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HC2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hc2_pkg.sv
package hc2_pkg;

    localparam int CHAR_W     = 8;
    localparam int CIPHER_W   = 7;
    localparam int KEY_W      = 5;
    localparam int CODE_W     = 5;
    localparam int PROD_W     = KEY_W + CODE_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int RECIP_W    = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int QUOT_W     = 6;
    localparam int CFG_IDX_W  = 2;

    localparam int PAIR_DEPTH = 2;
    localparam int PAIR_PTR_W = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int PAIR_CNT_W = $clog2(PAIR_DEPTH + 1);

    localparam logic [CODE_W-1:0]  CODE_MOD = 5'd26;
    localparam logic [CODE_W-1:0]  PAD_CODE = 5'd23;
    localparam logic [RECIP_W-1:0] RECIP    = 12'd2521;

    localparam logic [CHAR_W-1:0]   ASCII_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0]   ASCII_UPPER_Z = 8'd90;
    localparam logic [CHAR_W-1:0]   ASCII_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0]   ASCII_LOWER_Z = 8'd122;
    localparam logic [CIPHER_W-1:0] CIPHER_BASE   = 7'd65;

    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        KEY_R0C0 = 2'd0,
        KEY_R0C1 = 2'd1,
        KEY_R1C0 = 2'd2,
        KEY_R1C1 = 2'd3
    } key_idx_t;

    typedef struct packed {
        code_t p1;
        code_t p2;
        logic  is_end;
    } pair_t;

    function automatic code_t reduce_key(input logic [KEY_W-1:0] k);
        code_t r;
        r = (k >= CODE_MOD) ? CODE_W'(k - CODE_MOD) : k;
        return r;
    endfunction

endpackage

FILE: hdl/hc2_front.sv
module hc2_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [hc2_pkg::CHAR_W-1:0] char_in,
    input  logic                      end_of_message,
    input  logic                      push,
    output logic                      full,
    input  logic                      pair_full,
    output logic                      pair_push,
    output hc2_pkg::pair_t            pair
);
    import hc2_pkg::*;

    logic  held_valid_reg, held_valid_next;
    code_t held_letter_reg, held_letter_next;
    logic  is_upper, is_lower, is_letter, accept;
    code_t code;

    assign full   = pair_full;
    assign accept = push && !pair_full;

    always_comb
    begin
        is_upper = (char_in >= ASCII_UPPER_A) && (char_in <= ASCII_UPPER_Z);
        is_lower = (char_in >= ASCII_LOWER_A) && (char_in <= ASCII_LOWER_Z);
        is_letter = is_upper || is_lower;
        code = is_lower ? CODE_W'(char_in - ASCII_LOWER_A) : CODE_W'(char_in - ASCII_UPPER_A);

        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        pair_push        = 1'b0;
        pair.p1          = held_letter_reg;
        pair.p2          = code;
        pair.is_end      = end_of_message;

        if (accept)
        begin
            if (is_letter && held_valid_reg)
            begin
                pair_push        = 1'b1;
                held_valid_next  = 1'b0;
                held_letter_next = '0;
            end
            else if (is_letter && end_of_message)
            begin
                // lone letter at end: pad it
                pair_push   = 1'b1;
                pair.p1     = code;
                pair.p2     = PAD_CODE;
            end
            else if (is_letter)
            begin
                held_valid_next  = 1'b1;
                held_letter_next = code;
            end
            else if (end_of_message && held_valid_reg)
            begin
                pair_push        = 1'b1;
                pair.p2          = PAD_CODE;
                held_valid_next  = 1'b0;
                held_letter_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
        end
        else
        begin
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
        end
    end

endmodule

FILE: hdl/hc2_pair_fifo.sv
module hc2_pair_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hc2_pkg::pair_t din,
    output logic           full,
    output logic           valid,
    output hc2_pkg::pair_t dout,
    input  logic           pop
);
    import hc2_pkg::*;

    pair_t                 mem_reg [PAIR_DEPTH];
    logic [PAIR_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PAIR_CNT_W-1:0] count_reg;
    logic                  do_push, do_pop;

    assign full    = (count_reg == PAIR_CNT_W'(PAIR_DEPTH));
    assign valid   = (count_reg != '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    function automatic logic [PAIR_PTR_W-1:0] ptr_inc(input logic [PAIR_PTR_W-1:0] p);
        logic [PAIR_PTR_W-1:0] n;
        n = (p == PAIR_PTR_W'(PAIR_DEPTH - 1)) ? '0 : PAIR_PTR_W'(p + 1'b1);
        return n;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= PAIR_CNT_W'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= PAIR_CNT_W'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hdl/hc2_back.sv
module hc2_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hc2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hc2_pkg::KEY_W-1:0]     cfg_data,
    input  logic                          pair_valid,
    input  hc2_pkg::pair_t                pair,
    output logic                          pair_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [hc2_pkg::CIPHER_W-1:0]  cipher_char,
    output logic                          pair_last,
    output logic                          message_last
);
    import hc2_pkg::*;

    `include "hill_cipher_2x2_encrypt_unit_assert.svh"

    code_t k00_reg, k01_reg, k10_reg, k11_reg;

    logic              s1_valid_reg, s2_valid_reg, out_valid_reg, phase_reg;
    logic [SUM_W-1:0]  s1_sum0_reg, s1_sum1_reg, s2_sum0_reg, s2_sum1_reg;
    logic              s1_end_reg, s2_end_reg, out_end_reg;
    logic [QUOT_W-1:0] s2_q0_reg, s2_q1_reg;
    code_t             out_c0_reg, out_c1_reg;

    logic                     out_ready, s2_ready, s1_ready;
    logic [SUM_W-1:0]         sum0, sum1;
    logic [SUM_W+RECIP_W-1:0] scaled0, scaled1;
    logic [SUM_W-1:0]         rem0, rem1;
    code_t                    out_code;

    assign out_ready = !out_valid_reg || (pop && phase_reg);
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pair_pop  = pair_valid && s1_ready;

    always_comb
    begin
        sum0 = SUM_W'(k00_reg * pair.p1) + SUM_W'(k01_reg * pair.p2);
        sum1 = SUM_W'(k10_reg * pair.p1) + SUM_W'(k11_reg * pair.p2);
        // quotient by 26 via scaled reciprocal, exact for sums up to 1250
        scaled0 = (SUM_W+RECIP_W)'(s1_sum0_reg) * (SUM_W+RECIP_W)'(RECIP);
        scaled1 = (SUM_W+RECIP_W)'(s1_sum1_reg) * (SUM_W+RECIP_W)'(RECIP);
        rem0 = SUM_W'(s2_sum0_reg - SUM_W'(s2_q0_reg) * SUM_W'(CODE_MOD));
        rem1 = SUM_W'(s2_sum1_reg - SUM_W'(s2_q1_reg) * SUM_W'(CODE_MOD));
        out_code = phase_reg ? out_c1_reg : out_c0_reg;
    end

    assign empty        = !out_valid_reg;
    assign cipher_char  = CIPHER_W'(out_code) + CIPHER_BASE;
    assign pair_last    = phase_reg;
    assign message_last = phase_reg && out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k00_reg       <= 5'd9;
            k01_reg       <= 5'd4;
            k10_reg       <= 5'd5;
            k11_reg       <= 5'd7;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (key_idx_t'(cfg_index))
                    KEY_R0C0: k00_reg <= reduce_key(cfg_data);
                    KEY_R0C1: k01_reg <= reduce_key(cfg_data);
                    KEY_R1C0: k10_reg <= reduce_key(cfg_data);
                    KEY_R1C1: k11_reg <= reduce_key(cfg_data);
                endcase
            end
            if (s1_ready)
            begin
                s1_valid_reg <= pair_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
                phase_reg     <= 1'b0;
            end
            else if (pop && !phase_reg)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_sum0_reg <= sum0;
            s1_sum1_reg <= sum1;
            s1_end_reg  <= pair.is_end;
        end
        if (s2_ready)
        begin
            s2_sum0_reg <= s1_sum0_reg;
            s2_sum1_reg <= s1_sum1_reg;
            s2_q0_reg   <= scaled0[RECIP_SHIFT +: QUOT_W];
            s2_q1_reg   <= scaled1[RECIP_SHIFT +: QUOT_W];
            s2_end_reg  <= s1_end_reg;
        end
        if (out_ready)
        begin
            out_c0_reg  <= CODE_W'(rem0);
            out_c1_reg  <= CODE_W'(rem1);
            out_end_reg <= s2_end_reg;
        end
    end

    `HC2_ASSERT_NOW(a_letter_range, !empty, (cipher_char >= CIPHER_BASE) && (out_code < CODE_MOD), "cipher letter out of range")
    `HC2_ASSERT_NOW(a_last_on_second, !empty && message_last, pair_last, "message end not on second letter")
    `HC2_ASSERT_NEXT(a_second_follows, pop && !empty && !pair_last, !empty && pair_last, "second letter of pair missing")

endmodule

FILE: hdl/hill_cipher_2x2_encrypt_unit.sv
// 2x2 hill cipher encryptor.
// input side is a queue: drive char_in and end_of_message with push; a beat is
// taken on a clock edge with push high and full low. non-letters are dropped,
// lowercase is folded to uppercase, letters are paired.
// result side is a queue: while empty is low the oldest ciphertext letter sits on
// cipher_char with pair_last and message_last; pop high takes the beat.
// each pair gives two beats; pair_last marks the second, message_last marks the
// final letter of a message. a lone letter at end of message is padded with x.
// key entries are written through cfg_write/cfg_index/cfg_data while idle; the
// user must keep to that, the block does not enforce it. a completed pair passes
// the pair queue and registers s1, s2 and out before its first letter is visible;
// the second follows on the next pop. throughput: one input beat per cycle while
// full is low; the output port moves one letter per cycle while pop is high.
// a two-entry pair queue sits between classifier and arithmetic pipeline; when
// the receiver stalls, the pipeline and then the queue fill and full rises.
// reset clears the held letter, the queue and the pipeline and loads key 9 4 5 7.
module hill_cipher_2x2_encrypt_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hc2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hc2_pkg::KEY_W-1:0]     cfg_data,
    input  logic [hc2_pkg::CHAR_W-1:0]    char_in,
    input  logic                          end_of_message,
    input  logic                          push,
    output logic                          full,
    output logic [hc2_pkg::CIPHER_W-1:0]  cipher_char,
    output logic                          pair_last,
    output logic                          message_last,
    output logic                          empty,
    input  logic                          pop
);
    import hc2_pkg::*;

    logic  q_push, q_full, q_valid, q_pop;
    pair_t q_din, q_dout;

    hc2_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_in        (char_in),
        .end_of_message (end_of_message),
        .push           (push),
        .full           (full),
        .pair_full      (q_full),
        .pair_push      (q_push),
        .pair           (q_din)
    );

    hc2_pair_fifo u_pair_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .valid (q_valid),
        .dout  (q_dout),
        .pop   (q_pop)
    );

    hc2_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pair_valid   (q_valid),
        .pair         (q_dout),
        .pair_pop     (q_pop),
        .empty        (empty),
        .pop          (pop),
        .cipher_char  (cipher_char),
        .pair_last    (pair_last),
        .message_last (message_last)
    );

endmodule
